>>> sv/whp_pkg.sv
// Shared types and constants for the WAV header parser.
// No dependencies; imported by whp_ctrl, whp_dp, wav_header_parser and tb_wav_header_parser.
`default_nettype none

package whp_pkg;

	localparam int unsigned OutDataW = 136;

	// result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_RIFF  = 3'd1;
	localparam logic [2:0] ST_NO_WAVE  = 3'd2;
	localparam logic [2:0] ST_NO_FMT   = 3'd3;
	localparam logic [2:0] ST_NOT_PCM  = 3'd4;
	localparam logic [2:0] ST_NO_DATA  = 3'd5;
	localparam logic [2:0] ST_BAD_FMT  = 3'd6;

	// little-endian four-character tags
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
	localparam logic [31:0] TAG_FACT = 32'h7463_6166;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [31:0] FMT_BASE_LEN = 32'd16;
	localparam logic [15:0] FMT_PCM      = 16'd1;

	typedef struct packed {
		logic        clear;
		logic        count;
		logic        skip_dec;
		logic        shift;
		logic        field_done;
		logic        load_skip_fmt;
		logic        load_skip_fact;
		logic        load_chan;
		logic        load_rate;
		logic        load_bits;
		logic        div_start;
		logic        div_second;
		logic        emit;
		logic        emit_ok;
		logic [2:0]  emit_status;
	} whp_cmd_t;

	typedef struct packed {
		logic [31:0] field_val;
		logic [1:0]  bif;
		logic        skip_last;
		logic        skip_nz;
		logic        bad_fmt;
		logic        div_busy;
		logic        div_done;
		logic [31:0] quotient;
		logic [15:0] held_channels;
		logic [31:0] held_rate;
		logic [15:0] held_bits;
		logic [31:0] bytes_next;
	} whp_stat_t;

endpackage

`default_nettype wire

>>> sv/whp_div.sv
// Restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit a cycle.
// No dependencies.
`default_nettype none

module whp_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [15:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [31:0]      quotient
);

	logic [15:0] rem_q;
	logic [31:0] quo_q;
	logic [15:0] dsr_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [16:0] trial;
	logic        ge;
	logic [16:0] diff;

	assign trial = {rem_q, quo_q[31]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[15:0] : trial[15:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

>>> sv/whp_dp.sv
// Datapath: field assembly, skip counter, latched fmt values, byte count, divider.
// Depends on whp_pkg and whp_div.
`default_nettype none

module whp_dp
	import whp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  file_byte,
	input  wire whp_cmd_t    cmd,
	output whp_stat_t        stat
);

	logic [31:0] shift_q;
	logic [1:0]  bif_q;
	logic [31:0] skip_q;
	logic [15:0] chan_q;
	logic [31:0] rate_q;
	logic [15:0] bits_q;
	logic [31:0] bytes_q;

	logic [31:0] base_shift;
	logic [1:0]  base_bif;
	logic [31:0] base_bytes;
	logic [31:0] field_now;
	logic [31:0] skip_next;
	logic [31:0] bytes_next;

	logic        div_busy;
	logic        div_done;
	logic [31:0] div_quo;
	logic [31:0] div_dividend;
	logic [15:0] div_divisor;

	// a start mark clears parse state in the same cycle that takes its byte
	assign base_shift = cmd.clear ? '0 : shift_q;
	assign base_bif   = cmd.clear ? '0 : bif_q;
	assign base_bytes = cmd.clear ? '0 : bytes_q;
	assign field_now  = base_shift | ({24'd0, file_byte} << {base_bif, 3'b000});
	assign skip_next  = skip_q - 32'd1;
	assign bytes_next = cmd.count ? base_bytes + 32'd1 : base_bytes;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			bif_q   <= '0;
			skip_q  <= '0;
			chan_q  <= '0;
			rate_q  <= '0;
			bits_q  <= '0;
			bytes_q <= '0;
		end else begin
			if (cmd.field_done) begin
				shift_q <= '0;
				bif_q   <= '0;
			end else if (cmd.shift) begin
				shift_q <= field_now;
				bif_q   <= base_bif + 2'd1;
			end else begin
				shift_q <= base_shift;
				bif_q   <= base_bif;
			end

			if (cmd.load_skip_fmt) begin
				skip_q <= (field_now > FMT_BASE_LEN) ? field_now - FMT_BASE_LEN : '0;
			end else if (cmd.load_skip_fact) begin
				skip_q <= field_now;
			end else if (cmd.skip_dec) begin
				skip_q <= skip_next;
			end else if (cmd.clear) begin
				skip_q <= '0;
			end

			if (cmd.load_chan) begin
				chan_q <= field_now[15:0];
			end else if (cmd.clear) begin
				chan_q <= '0;
			end
			if (cmd.load_rate) begin
				rate_q <= field_now;
			end else if (cmd.clear) begin
				rate_q <= '0;
			end
			if (cmd.load_bits) begin
				bits_q <= field_now[15:0];
			end else if (cmd.clear) begin
				bits_q <= '0;
			end

			bytes_q <= bytes_next;
		end
	end

	// first pass: size / channels, second pass: that / bytes per sample
	assign div_dividend = cmd.div_second ? div_quo : field_now;
	assign div_divisor  = cmd.div_second ? {3'd0, bits_q[15:3]} : chan_q;

	whp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		stat.field_val     = field_now;
		stat.bif           = base_bif;
		stat.skip_last     = (skip_next == '0);
		stat.skip_nz       = (skip_q != '0);
		stat.bad_fmt       = (chan_q == '0) || (bits_q[15:3] == '0);
		stat.div_busy      = div_busy;
		stat.div_done      = div_done;
		stat.quotient      = div_quo;
		stat.held_channels = chan_q;
		stat.held_rate     = rate_q;
		stat.held_bits     = bits_q;
		stat.bytes_next    = bytes_next;
	end

endmodule

`default_nettype wire

>>> sv/whp_ctrl.sv
// Controller: parse phase state machine, issues datapath commands per byte.
// Depends on whp_pkg.
`default_nettype none

module whp_ctrl
	import whp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      accept,
	input  wire logic      first_of_file,
	input  wire whp_stat_t stat,
	output whp_cmd_t       cmd,
	output logic           busy
);

	localparam logic [4:0] P_IDLE     = 5'd0;
	localparam logic [4:0] P_RIFF     = 5'd1;
	localparam logic [4:0] P_RLEN     = 5'd2;
	localparam logic [4:0] P_WAVE     = 5'd3;
	localparam logic [4:0] P_FMT      = 5'd4;
	localparam logic [4:0] P_FSIZE    = 5'd5;
	localparam logic [4:0] P_FTYPE    = 5'd6;
	localparam logic [4:0] P_CHAN     = 5'd7;
	localparam logic [4:0] P_RATE     = 5'd8;
	localparam logic [4:0] P_BRATE    = 5'd9;
	localparam logic [4:0] P_ALIGN    = 5'd10;
	localparam logic [4:0] P_BITS     = 5'd11;
	localparam logic [4:0] P_FSKIP    = 5'd12;
	localparam logic [4:0] P_TAG1     = 5'd13;
	localparam logic [4:0] P_FACTSZ   = 5'd14;
	localparam logic [4:0] P_FACTSKIP = 5'd15;
	localparam logic [4:0] P_TAG2     = 5'd16;
	localparam logic [4:0] P_DSIZE    = 5'd17;
	localparam logic [4:0] P_DONE     = 5'd18;
	localparam logic [4:0] P_DIV1     = 5'd19;
	localparam logic [4:0] P_DIV2     = 5'd20;

	logic [4:0] phase_q;
	logic [4:0] phase_d;
	logic [4:0] phase_eff;
	logic       restart;
	logic       active;
	logic       len2;
	logic       last;
	logic [31:0] v;

	assign restart   = accept && first_of_file;
	assign phase_eff = restart ? P_RIFF : phase_q;
	assign active    = accept && (phase_eff inside {[P_RIFF:P_DSIZE]});
	assign len2      = phase_eff inside {P_FTYPE, P_CHAN, P_ALIGN, P_BITS};
	assign last      = stat.bif == (len2 ? 2'd1 : 2'd3);
	assign v         = stat.field_val;
	assign busy      = (phase_q == P_DIV1) || (phase_q == P_DIV2);

	always_comb begin
		cmd       = '0;
		cmd.clear = restart;
		phase_d   = phase_eff;
		if (active) begin
			cmd.count = 1'b1;
			if (phase_eff == P_FSKIP || phase_eff == P_FACTSKIP) begin
				cmd.skip_dec = 1'b1;
				if (stat.skip_last) begin
					phase_d = (phase_eff == P_FSKIP) ? P_TAG1 : P_TAG2;
				end
			end else if (!last) begin
				cmd.shift = 1'b1;
			end else begin
				cmd.field_done = 1'b1;
				case (phase_eff)
					P_RIFF: begin
						if (v != TAG_RIFF) begin
							cmd.emit        = 1'b1;
							cmd.emit_status = ST_NO_RIFF;
							phase_d         = P_DONE;
						end else begin
							phase_d = P_RLEN;
						end
					end
					P_RLEN:  phase_d = P_WAVE;
					P_WAVE: begin
						if (v != TAG_WAVE) begin
							cmd.emit        = 1'b1;
							cmd.emit_status = ST_NO_WAVE;
							phase_d         = P_DONE;
						end else begin
							phase_d = P_FMT;
						end
					end
					P_FMT: begin
						if (v != TAG_FMT) begin
							cmd.emit        = 1'b1;
							cmd.emit_status = ST_NO_FMT;
							phase_d         = P_DONE;
						end else begin
							phase_d = P_FSIZE;
						end
					end
					P_FSIZE: begin
						cmd.load_skip_fmt = 1'b1;
						phase_d           = P_FTYPE;
					end
					P_FTYPE: begin
						if (v != {16'd0, FMT_PCM}) begin
							cmd.emit        = 1'b1;
							cmd.emit_status = ST_NOT_PCM;
							phase_d         = P_DONE;
						end else begin
							phase_d = P_CHAN;
						end
					end
					P_CHAN: begin
						cmd.load_chan = 1'b1;
						phase_d       = P_RATE;
					end
					P_RATE: begin
						cmd.load_rate = 1'b1;
						phase_d       = P_BRATE;
					end
					P_BRATE: phase_d = P_ALIGN;
					P_ALIGN: phase_d = P_BITS;
					P_BITS: begin
						cmd.load_bits = 1'b1;
						phase_d       = stat.skip_nz ? P_FSKIP : P_TAG1;
					end
					P_TAG1: begin
						if (v == TAG_FACT) begin
							phase_d = P_FACTSZ;
						end else if (v == TAG_DATA) begin
							phase_d = P_DSIZE;
						end else begin
							cmd.emit        = 1'b1;
							cmd.emit_status = ST_NO_DATA;
							phase_d         = P_DONE;
						end
					end
					P_FACTSZ: begin
						cmd.load_skip_fact = 1'b1;
						phase_d            = (v != '0) ? P_FACTSKIP : P_TAG2;
					end
					P_TAG2: begin
						if (v != TAG_DATA) begin
							cmd.emit        = 1'b1;
							cmd.emit_status = ST_NO_DATA;
							phase_d         = P_DONE;
						end else begin
							phase_d = P_DSIZE;
						end
					end
					P_DSIZE: begin
						if (stat.bad_fmt) begin
							cmd.emit        = 1'b1;
							cmd.emit_status = ST_BAD_FMT;
							phase_d         = P_DONE;
						end else begin
							cmd.div_start = 1'b1;
							phase_d       = P_DIV1;
						end
					end
					default: phase_d = P_DONE;
				endcase
			end
		end else if (phase_q == P_DIV1 && stat.div_done) begin
			cmd.div_start  = 1'b1;
			cmd.div_second = 1'b1;
			phase_d        = P_DIV2;
		end else if (phase_q == P_DIV2 && stat.div_done) begin
			cmd.emit        = 1'b1;
			cmd.emit_ok     = 1'b1;
			cmd.emit_status = ST_OK;
			phase_d         = P_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

endmodule

`default_nettype wire

>>> sv/wav_header_parser.sv
// WAV (RIFF/WAVE PCM) header parser: one file byte per transaction, at most one result per file.
// One byte per cycle; input stalls while the divider runs or a result waits untaken.
// Error results are registered and valid in the cycle after the offending byte. A good
// header's result follows two divider passes after the last data-size byte (size/channels,
// then /bytes-per-sample), the done of each handing off; no byte is taken meanwhile.
// Reset (arst_n low, async): parser waits for a start mark, output register empty. Uses whp_*.
`default_nettype none

module wav_header_parser
	import whp_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// input stream
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [7:0]          s_tdata,  // [7:0] file_byte
	input  wire logic                s_tuser,  // [0] first_of_file
	// result stream
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// [2:0] status, [18:3] channel_count, [50:19] rate_hz,
	// [66:51] sample_width, [98:67] sample_count, [130:99] header_bytes, rest zero
	output logic [OutDataW-1:0]      m_tdata
);

	whp_cmd_t  cmd;
	whp_stat_t stat;
	logic      ctrl_busy;
	logic      accept;
	logic      out_free;

	logic                m_valid_q;
	logic [OutDataW-1:0] m_data_q;
	logic [31:0]         count_val;

	// The output register frees in the same cycle it is taken, so a byte that
	// raises a result always finds room. Input stalls while dividing and while
	// a result waits untaken.
	assign out_free = !m_valid_q || m_tready;
	assign s_tready = !ctrl_busy && out_free;
	assign accept   = s_tvalid && s_tready;

	whp_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.first_of_file (s_tuser),
		.stat          (stat),
		.cmd           (cmd),
		.busy          (ctrl_busy)
	);

	whp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.file_byte (s_tdata),
		.cmd       (cmd),
		.stat      (stat)
	);

	// sample count is zero on every error result
	assign count_val = cmd.emit_ok ? stat.quotient : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// header_bytes: byte count including the byte that raised the result; during
	// division no byte is taken, so it holds the count at the data-size field
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_data_q <= {5'd0, stat.bytes_next, count_val, stat.held_bits,
				stat.held_rate, stat.held_channels, cmd.emit_status};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

`ifndef SYNTH
	// a result is never loaded over one that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("result register overwritten");

	// the divider is only started when idle
	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !stat.div_busy)
		else $error("divider started while busy");

	// a good result only follows completion of the second division pass
	a_ok_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_ok |-> (stat.div_done && ctrl_busy && !accept))
		else $error("ok result without finished division");

	// no byte is taken while the divider runs
	a_no_accept_div: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_busy |-> !accept)
		else $error("byte accepted during division");
`endif

endmodule

`default_nettype wire

>>> tb/tb_wav_header_parser.sv
// Self-checking testbench for wav_header_parser: streams WAV headers byte by byte and
// compares every result transaction with a cycle-free header predictor or a hand-written result.
// Depends on whp_pkg (status codes, tags, result width) and the wav_header_parser RTL.

module tb_wav_header_parser;
	import whp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 3000;   // cycles without any transaction before giving up
	localparam int HOLD_CYCLES = 400;    // long receiver hold-off, fills the output side
	localparam int RAND_BYTES  = 850;
	localparam int MAX_SKIP    = 200;    // most skip bytes actually sent for one chunk

	// parser position, mirrors the walk through the header fields
	typedef enum logic [4:0] {
		PH_IDLE, PH_RIFF, PH_RLEN, PH_WAVE, PH_FMT, PH_FSIZE, PH_FTYPE, PH_CHAN,
		PH_RATE, PH_BRATE, PH_ALIGN, PH_BITS, PH_FSKIP, PH_TAG1, PH_FACTSZ,
		PH_FACTSKIP, PH_TAG2, PH_DSIZE, PH_DONE
	} hdr_phase_e;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] chan;
		logic [31:0] rate;
		logic [15:0] bits;
		logic [31:0] count;
		logic [31:0] hdr_len;
	} hdr_result_t;

	// layout of one generated file; tags and sizes may be broken on purpose
	typedef struct packed {
		logic [3:0]  lead;       // noise bytes before the start mark
		logic [31:0] tag_riff;
		logic [31:0] riff_len;
		logic [31:0] tag_wave;
		logic [31:0] tag_fmt;
		logic [31:0] fmt_size;
		logic [15:0] fmt_type;
		logic [15:0] chan;
		logic [31:0] rate;
		logic [31:0] brate;
		logic [15:0] align;
		logic [15:0] bits;
		logic [31:0] tag1;
		logic [31:0] fact_size;
		logic [31:0] tag2;
		logic [31:0] payload_len;
		logic [3:0]  trail;      // noise bytes after the file
		logic [15:0] cut;        // nonzero: file truncated to this many bytes
	} wav_layout_t;

	typedef struct packed {
		wav_layout_t layout;
		logic        typed;      // expected result written out by hand
		hdr_result_t want;
	} hdr_case_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [7:0]          s_tdata;   // [7:0] file_byte
	logic                s_tuser;   // [0] first_of_file
	logic                m_tvalid;
	logic                m_tready;
	// [2:0] status, [18:3] channel_count, [50:19] rate_hz,
	// [66:51] sample_width, [98:67] sample_count, [130:99] header_bytes
	logic [OutDataW-1:0] m_tdata;

	// predictor state
	hdr_phase_e  ph;
	logic [1:0]  pos;
	logic [31:0] acc;
	logic [31:0] skip_cnt;
	logic [15:0] h_chan;
	logic [31:0] h_rate;
	logic [15:0] h_bits;
	logic [31:0] nbytes;

	hdr_result_t expected_hdrs[$];
	hdr_case_t   dir_cases[$];
	logic [7:0]  file_q[$];

	int          fails = 0;
	int          bytes_sent = 0;
	int          quiet = 0;
	logic        calm = 1'b0;       // no idling on either side
	logic        hold_req = 1'b0;
	logic        typed_on = 1'b0;
	hdr_result_t typed_res;

	always #5 clk = ~clk;

	wav_header_parser i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// ---------------------------------------------------------------- predictor
	task automatic parse_byte(input logic [7:0] b, input logic first,
			output logic hit, output hdr_result_t r);
		logic [31:0] v;
		logic [31:0] cnt;
		logic [2:0]  st;
		logic        fire;
		int          need;
		hit  = 1'b0;
		r    = '0;
		fire = 1'b0;
		st   = ST_OK;
		cnt  = '0;
		if (first) begin
			pos = '0; acc = '0; skip_cnt = '0;
			h_chan = '0; h_rate = '0; h_bits = '0; nbytes = '0;
			ph = PH_RIFF;
		end
		if (ph != PH_IDLE && ph != PH_DONE) begin
			nbytes = nbytes + 32'd1;
			if (ph == PH_FSKIP || ph == PH_FACTSKIP) begin
				skip_cnt = skip_cnt - 32'd1;
				if (skip_cnt == 0)
					ph = (ph == PH_FSKIP) ? PH_TAG1 : PH_TAG2;
			end else begin
				acc = acc | ({24'b0, b} << (8 * pos));
				need = (ph == PH_FTYPE || ph == PH_CHAN || ph == PH_ALIGN || ph == PH_BITS)
					? 2 : 4;
				if (int'(pos) + 1 < need) begin
					pos = pos + 2'd1;
				end else begin
					v   = acc;
					acc = '0;
					pos = '0;
					case (ph)
						PH_RIFF: begin
							if (v != TAG_RIFF) begin fire = 1'b1; st = ST_NO_RIFF; end
							else ph = PH_RLEN;
						end
						PH_RLEN: ph = PH_WAVE;
						PH_WAVE: begin
							if (v != TAG_WAVE) begin fire = 1'b1; st = ST_NO_WAVE; end
							else ph = PH_FMT;
						end
						PH_FMT: begin
							if (v != TAG_FMT) begin fire = 1'b1; st = ST_NO_FMT; end
							else ph = PH_FSIZE;
						end
						PH_FSIZE: begin
							skip_cnt = (v > FMT_BASE_LEN) ? v - FMT_BASE_LEN : '0;
							ph = PH_FTYPE;
						end
						PH_FTYPE: begin
							if (v != {16'b0, FMT_PCM}) begin fire = 1'b1; st = ST_NOT_PCM; end
							else ph = PH_CHAN;
						end
						PH_CHAN: begin
							h_chan = v[15:0];
							ph = PH_RATE;
						end
						PH_RATE: begin
							h_rate = v;
							ph = PH_BRATE;
						end
						PH_BRATE: ph = PH_ALIGN;
						PH_ALIGN: ph = PH_BITS;
						PH_BITS: begin
							h_bits = v[15:0];
							ph = (skip_cnt != 0) ? PH_FSKIP : PH_TAG1;
						end
						PH_TAG1: begin
							if (v == TAG_FACT) ph = PH_FACTSZ;
							else if (v == TAG_DATA) ph = PH_DSIZE;
							else begin fire = 1'b1; st = ST_NO_DATA; end
						end
						PH_FACTSZ: begin
							skip_cnt = v;
							ph = (v != 0) ? PH_FACTSKIP : PH_TAG2;
						end
						PH_TAG2: begin
							if (v != TAG_DATA) begin fire = 1'b1; st = ST_NO_DATA; end
							else ph = PH_DSIZE;
						end
						PH_DSIZE: begin
							fire = 1'b1;
							if (h_chan == 0 || h_bits < 16'd8) begin
								st = ST_BAD_FMT;
							end else begin
								st  = ST_OK;
								cnt = (v / {16'b0, h_chan}) / {19'b0, h_bits[15:3]};
							end
						end
						default: ph = PH_DONE;
					endcase
				end
			end
		end
		if (fire) begin
			r   = {st, h_chan, h_rate, h_bits, cnt, nbytes};
			hit = 1'b1;
			ph  = PH_DONE;
		end
	endtask

	// ---------------------------------------------------------------- file builder
	function automatic void push16(input logic [15:0] v);
		file_q.push_back(v[7:0]);
		file_q.push_back(v[15:8]);
	endfunction

	function automatic void push32(input logic [31:0] v);
		push16(v[15:0]);
		push16(v[31:16]);
	endfunction

	function automatic wav_layout_t base_layout();
		wav_layout_t s;
		s.lead        = '0;
		s.tag_riff    = TAG_RIFF;
		s.riff_len    = 32'd36;
		s.tag_wave    = TAG_WAVE;
		s.tag_fmt     = TAG_FMT;
		s.fmt_size    = FMT_BASE_LEN;
		s.fmt_type    = FMT_PCM;
		s.chan        = 16'd2;
		s.rate        = 32'd44100;
		s.brate       = 32'd176400;
		s.align       = 16'd4;
		s.bits        = 16'd16;
		s.tag1        = TAG_DATA;
		s.fact_size   = '0;
		s.tag2        = TAG_DATA;
		s.payload_len = 32'd1024;
		s.trail       = '0;
		s.cut         = '0;
		return s;
	endfunction

	function automatic hdr_result_t mk_res(input logic [2:0] st, input logic [15:0] ch,
			input logic [31:0] rt, input logic [15:0] bt, input logic [31:0] cnt,
			input logic [31:0] hl);
		return {st, ch, rt, bt, cnt, hl};
	endfunction

	function automatic void add_case(input wav_layout_t s, input logic typed,
			input hdr_result_t want);
		hdr_case_t c;
		c.layout = s;
		c.typed  = typed;
		c.want   = want;
		dir_cases.push_back(c);
	endfunction

	// mostly well-formed headers with random content, some broken or cut short
	function automatic wav_layout_t rand_layout();
		wav_layout_t s;
		s = base_layout();
		s.riff_len    = $urandom;
		s.rate        = $urandom;
		s.brate       = $urandom;
		s.align       = 16'($urandom);
		s.payload_len = $urandom;
		case ($urandom_range(0, 15))
			0:       s.chan = 16'($urandom);
			1:       s.chan = '0;
			default: s.chan = 16'($urandom_range(1, 8));
		endcase
		case ($urandom_range(0, 15))
			0:       s.bits = 16'($urandom);
			1:       s.bits = 16'($urandom_range(0, 7));
			default: s.bits = 16'(8 * $urandom_range(1, 4));
		endcase
		case ($urandom_range(0, 7))
			0:       s.fmt_size = $urandom_range(0, 15);
			1:       s.fmt_size = 16 + $urandom_range(1, 12);
			default: s.fmt_size = FMT_BASE_LEN;
		endcase
		if ($urandom_range(0, 15) == 0)
			s.fmt_type = 16'($urandom);
		case ($urandom_range(0, 15))
			0, 1, 2, 3: begin
				s.tag1      = TAG_FACT;
				s.fact_size = $urandom_range(0, 12);
			end
			4:       s.tag1 = $urandom;
			default: s.tag1 = TAG_DATA;
		endcase
		if ($urandom_range(0, 15) == 0)
			s.tag2 = $urandom;
		// sometimes a single flipped bit in one of the leading tags
		case ($urandom_range(0, 11))
			0:       s.tag_riff = s.tag_riff ^ (32'd1 << $urandom_range(0, 31));
			1:       s.tag_wave = s.tag_wave ^ (32'd1 << $urandom_range(0, 31));
			2:       s.tag_fmt  = s.tag_fmt ^ (32'd1 << $urandom_range(0, 31));
			default: ;
		endcase
		if ($urandom_range(0, 7) == 0)
			s.lead = 4'($urandom_range(1, 3));
		s.trail = 4'($urandom_range(0, 3));
		// aborted file: next start mark lands in the middle, sometimes inside a huge skip
		if ($urandom_range(0, 9) == 0) begin
			s.cut = 16'($urandom_range(1, 50));
			if ($urandom_range(0, 1) == 0)
				s.fmt_size = $urandom | 32'h100;
		end
		return s;
	endfunction

	// ---------------------------------------------------------------- drivers
	task automatic send_byte(input logic [7:0] b, input logic first);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = b;
		s_tuser  = first;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_file(input wav_layout_t s);
		logic [31:0] n;
		file_q.delete();
		push32(s.tag_riff);
		push32(s.riff_len);
		push32(s.tag_wave);
		push32(s.tag_fmt);
		push32(s.fmt_size);
		push16(s.fmt_type);
		push16(s.chan);
		push32(s.rate);
		push32(s.brate);
		push16(s.align);
		push16(s.bits);
		n = (s.fmt_size > FMT_BASE_LEN) ? s.fmt_size - FMT_BASE_LEN : '0;
		if (n > MAX_SKIP) n = MAX_SKIP;
		repeat (n) file_q.push_back(8'($urandom));
		push32(s.tag1);
		if (s.tag1 == TAG_FACT) begin
			push32(s.fact_size);
			n = (s.fact_size > MAX_SKIP) ? MAX_SKIP : s.fact_size;
			repeat (n) file_q.push_back(8'($urandom));
			push32(s.tag2);
		end
		push32(s.payload_len);
		if (s.cut != 0)
			while (file_q.size() > s.cut) void'(file_q.pop_back());
		repeat (s.lead) send_byte(8'($urandom), 1'b0);
		foreach (file_q[i]) send_byte(file_q[i], i == 0);
		repeat (s.trail) send_byte(8'($urandom), 1'b0);
	endtask

	// receiver: short random stalls, one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready = 1'b0;
				hold_req = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(0, 4)) @(negedge clk);
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- checking
	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fails++;
		end
	endtask

	// input transactions feed the predictor, output transactions are checked
	always @(posedge clk) begin : scoreboard
		logic        hit;
		hdr_result_t p;
		hdr_result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				parse_byte(s_tdata, s_tuser, hit, p);
				if (hit)
					expected_hdrs.push_back(typed_on ? typed_res : p);
			end
			if (m_tvalid && m_tready) begin
				if (expected_hdrs.size() == 0) begin
					$error("result transaction with nothing expected, status %0d",
						m_tdata[2:0]);
					fails++;
				end else begin
					want = expected_hdrs.pop_front();
					check_field("status", 32'(want.status), 32'(m_tdata[2:0]));
					check_field("channel_count", 32'(want.chan), 32'(m_tdata[18:3]));
					check_field("rate_hz", want.rate, m_tdata[50:19]);
					check_field("sample_width", 32'(want.bits), 32'(m_tdata[66:51]));
					check_field("sample_count", want.count, m_tdata[98:67]);
					check_field("header_bytes", want.hdr_len, m_tdata[130:99]);
					check_field("padding", 32'd0, 32'(m_tdata[OutDataW-1:131]));
				end
			end
		end
	end

	// watchdog on a stream that stopped moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("tb_wav_header_parser NOT OK");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- sequence
	initial begin
		wav_layout_t s;
		int          nfile;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		ph       = PH_IDLE;
		pos      = '0;
		acc      = '0;
		skip_cnt = '0;
		h_chan   = '0;
		h_rate   = '0;
		h_bits   = '0;
		nbytes   = '0;
		typed_res = '0;

		// directed cases: each tag error, bad format, extremes, optional chunks
		s = base_layout(); s.lead = 4'd2; s.tag_riff = TAG_RIFF ^ 32'h0100_0000;
		add_case(s, 1'b1, mk_res(ST_NO_RIFF, 0, 0, 0, 0, 4));
		s = base_layout(); s.tag_wave = TAG_FACT;
		add_case(s, 1'b1, mk_res(ST_NO_WAVE, 0, 0, 0, 0, 12));
		s = base_layout(); s.tag_fmt = TAG_DATA;
		add_case(s, 1'b1, mk_res(ST_NO_FMT, 0, 0, 0, 0, 16));
		s = base_layout(); s.fmt_type = 16'hFFFF;
		add_case(s, 1'b1, mk_res(ST_NOT_PCM, 0, 0, 0, 0, 22));
		s = base_layout(); s.tag1 = TAG_FMT;
		add_case(s, 1'b1, mk_res(ST_NO_DATA, 2, 44100, 16, 0, 40));
		// fact chunk followed by something other than data
		s = base_layout(); s.tag1 = TAG_FACT; s.fact_size = 32'd4; s.tag2 = TAG_FACT;
		add_case(s, 1'b0, '0);
		s = base_layout(); s.chan = '0;
		add_case(s, 1'b1, mk_res(ST_BAD_FMT, 0, 44100, 16, 0, 44));
		s = base_layout(); s.bits = 16'd7;
		add_case(s, 1'b1, mk_res(ST_BAD_FMT, 2, 44100, 7, 0, 44));
		s = base_layout(); s.chan = 16'd1; s.bits = 16'd8; s.payload_len = '1;
		add_case(s, 1'b1, mk_res(ST_OK, 1, 44100, 8, 32'hFFFF_FFFF, 44));
		// all-ones fields, widest divisors
		s = base_layout(); s.riff_len = '1; s.chan = '1; s.rate = '1; s.brate = '1;
		s.align = '1; s.bits = '1; s.payload_len = '1;
		add_case(s, 1'b0, '0);
		// extended fmt chunk plus fact chunk
		s = base_layout(); s.fmt_size = 32'd20; s.tag1 = TAG_FACT; s.fact_size = 32'd4;
		add_case(s, 1'b0, '0);
		// fmt size below 16 skips nothing
		s = base_layout(); s.fmt_size = '0;
		add_case(s, 1'b0, '0);
		// empty fact chunk goes straight to the data tag
		s = base_layout(); s.tag1 = TAG_FACT; s.fact_size = '0; s.payload_len = 32'd6000;
		add_case(s, 1'b0, '0);
		// restart mark in the middle of a huge fmt skip
		s = base_layout(); s.fmt_size = '1; s.cut = 16'd60;
		add_case(s, 1'b0, '0);
		s = base_layout(); s.chan = 16'd1; s.bits = 16'd24; s.rate = 32'd8000;
		s.payload_len = '0; s.trail = 4'd3;
		add_case(s, 1'b1, mk_res(ST_OK, 1, 8000, 24, 0, 44));
		s = base_layout(); s.riff_len = '0; s.rate = '0; s.brate = '0; s.align = '0;
		s.payload_len = '0;
		add_case(s, 1'b0, '0);

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_cases[i]) begin
			typed_on  = dir_cases[i].typed;
			typed_res = dir_cases[i].want;
			send_file(dir_cases[i].layout);
		end
		typed_on = 1'b0;

		bytes_sent = 0;
		nfile = 0;
		while (bytes_sent < RAND_BYTES) begin
			if (nfile == 3)
				hold_req = 1'b1;
			// the tail of the run goes at full rate
			if (bytes_sent > RAND_BYTES - 300)
				calm = 1'b1;
			send_file(rand_layout());
			nfile++;
		end
		s_tvalid = 1'b0;

		while (expected_hdrs.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fails == 0 && expected_hdrs.size() == 0)
			$display("tb_wav_header_parser OK");
		else
			$display("tb_wav_header_parser NOT OK");
		$finish;
	end

endmodule

>>> files.f
sv/whp_pkg.sv
sv/whp_div.sv
sv/whp_dp.sv
sv/whp_ctrl.sv
sv/wav_header_parser.sv
tb/tb_wav_header_parser.sv
